FILE: src/pss_pkg.sv
// package with shared types and constants of the priority sleep task scheduler
`default_nettype none
package pss_pkg;

    localparam int KIND_W = 2;
    localparam int MODE_W = 3;
    localparam int PRIO_W = 7;
    localparam int CNT_W  = 16;
    localparam int TIDX_W = 3;

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_READY    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RUNNING  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SLEEPING = 3'd2;
    localparam logic [MODE_W-1:0] MODE_KILLED   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FINISHED = 3'd4;

    localparam logic [PRIO_W-1:0] PRIO_LIMIT = 7'd100;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  count;
        logic [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]  reload;
    } t_entry;

    typedef struct packed {
        logic   mode_we;
        logic   count_we;
        logic   load_we;
        t_entry data;
    } t_tbl_wr;

    typedef struct packed {
        logic write_back;
        logic cand;
    } t_upd_res;

endpackage
`default_nettype wire

FILE: src/pss_task_table.sv
// task entry register file with one write port and one registered read port
`default_nettype none
module pss_task_table #(
    parameter int NUM_TASKS = 8,
    parameter int IW        = 3
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pss_pkg::t_tbl_wr i_wr,
    input  wire logic [IW-1:0]   i_wr_idx,
    input  wire logic [IW-1:0]   i_rd_idx,
    output pss_pkg::t_entry      o_rd_entry,
    output logic                 o_rd_in_use
);
    import pss_pkg::*;

    logic [NUM_TASKS-1:0] r_in_use;
    t_entry               r_mem [NUM_TASKS];
    t_entry               r_rd_entry;
    logic                 r_rd_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
        end else if (i_wr.load_we) begin
            r_in_use[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.mode_we) begin
            r_mem[i_wr_idx].mode <= i_wr.data.mode;
        end
        if (i_wr.count_we) begin
            r_mem[i_wr_idx].count <= i_wr.data.count;
        end
        if (i_wr.load_we) begin
            r_mem[i_wr_idx].prio   <= i_wr.data.prio;
            r_mem[i_wr_idx].reload <= i_wr.data.reload;
        end
    end

    // read address is the index of the next cycle
    always_ff @(posedge i_clk) begin
        r_rd_entry  <= r_mem[i_rd_idx];
        r_rd_in_use <= r_in_use[i_rd_idx];
    end

    assign o_rd_entry  = r_rd_entry;
    assign o_rd_in_use = r_rd_in_use;

endmodule
`default_nettype wire

FILE: src/pss_upd_unit.sv
// shared per-entry tick update and priority compare unit
`default_nettype none
module pss_upd_unit (
    input  wire pss_pkg::t_entry         i_entry,
    input  wire logic                    i_in_use,
    input  wire logic [pss_pkg::PRIO_W-1:0] i_best_prio,
    output pss_pkg::t_entry              o_entry,
    output pss_pkg::t_upd_res            o_res
);
    import pss_pkg::*;

    always_comb begin
        o_entry = i_entry;
        if (i_entry.count == '0) begin
            o_entry.mode  = MODE_READY;
            o_entry.count = i_entry.reload;
        end else if (i_entry.mode == MODE_RUNNING) begin
            o_entry.mode = MODE_SLEEPING;
        end else if (i_entry.mode == MODE_SLEEPING) begin
            o_entry.count = i_entry.count - CNT_W'(1);
        end else if (i_entry.mode == MODE_KILLED) begin
            o_entry.mode = MODE_FINISHED;
        end
        o_res.write_back = i_in_use;
        o_res.cand = i_in_use && (o_entry.mode == MODE_READY) && (i_entry.prio < i_best_prio);
    end

endmodule
`default_nettype wire

FILE: src/priority_sleep_task_scheduler.sv
// top level of the priority sleep task scheduler
// usage:
//   s_axis carries one item per transaction; tuser holds the kind (tick, assign,
//   fail), tdata holds the assign fields. m_axis returns one result per enabled
//   tick: tuser is the dispatched flag, tdata the chosen task index.
//   the cfg channel writes run_enable; write it only while the block is idle.
// operation:
//   assign, fail, disabled ticks and unused kinds take effect at the accepting
//   edge and the block is ready again in the next cycle.
//   an enabled tick is accepted in idle, passes each task entry in turn through
//   the shared update and compare unit in the scan state, then marks the winner
//   running and loads the result register; no new item is accepted until done.
//   the result register holds the result until m_axis_tready; new items are
//   accepted meanwhile, but a following enabled tick waits in its last step
//   until the previous result has been taken.
// reset:
//   synchronous active-low reset clears run_enable, all in-use bits, the
//   dispatch history and the output valid; the task table needs no clearing.
`default_nettype none
module priority_sleep_task_scheduler #(
    parameter int NUM_TASKS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // task_index, new_priority, new_count, new_reload, new_state
    input  wire logic [1:0]  s_axis_tuser,  // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // chosen_task
    output logic [0:0]       m_axis_tuser,  // dispatched
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_data     // run_enable
);
    import pss_pkg::*;

    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DISP = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    logic [PRIO_W-1:0] r_best_prio, n_best_prio;
    logic              r_found, n_found;
    logic [IW-1:0]     r_last, n_last;
    logic              r_disp_made, n_disp_made;
    logic              r_run;
    logic              r_out_valid, n_out_valid;
    logic              r_out_disp, n_out_disp;
    logic [TIDX_W-1:0] r_out_task, n_out_task;

    logic              in_accept;
    logic [KIND_W-1:0] in_kind;
    logic [TIDX_W-1:0] in_idx;
    t_entry            in_entry;
    logic              out_free;

    t_tbl_wr           tbl_wr;
    logic [IW-1:0]     tbl_wr_idx;
    t_entry            rd_entry;
    logic              rd_in_use;
    t_entry            upd_entry;
    t_upd_res          upd_res;

    assign in_kind         = s_axis_tuser;
    assign in_idx          = s_axis_tdata[2:0];
    assign in_entry.prio   = s_axis_tdata[9:3];
    assign in_entry.count  = s_axis_tdata[25:10];
    assign in_entry.reload = s_axis_tdata[41:26];
    assign in_entry.mode   = s_axis_tdata[44:42];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    pss_task_table #(
        .NUM_TASKS (NUM_TASKS),
        .IW        (IW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (tbl_wr),
        .i_wr_idx    (tbl_wr_idx),
        .i_rd_idx    (n_idx),
        .o_rd_entry  (rd_entry),
        .o_rd_in_use (rd_in_use)
    );

    pss_upd_unit u_upd (
        .i_entry     (rd_entry),
        .i_in_use    (rd_in_use),
        .i_best_prio (r_best_prio),
        .o_entry     (upd_entry),
        .o_res       (upd_res)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_best_idx  = r_best_idx;
        n_best_prio = r_best_prio;
        n_found     = r_found;
        n_last      = r_last;
        n_disp_made = r_disp_made;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_disp  = r_out_disp;
        n_out_task  = r_out_task;
        tbl_wr      = '0;
        tbl_wr_idx  = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    case (in_kind)
                        KIND_ASSIGN: begin
                            if (32'(in_idx) < NUM_TASKS) begin
                                tbl_wr.mode_we  = 1'b1;
                                tbl_wr.count_we = 1'b1;
                                tbl_wr.load_we  = 1'b1;
                                tbl_wr.data     = in_entry;
                                tbl_wr_idx      = IW'(in_idx);
                            end
                        end
                        KIND_FAIL: begin
                            if (r_disp_made) begin
                                tbl_wr.mode_we   = 1'b1;
                                tbl_wr.data.mode = MODE_KILLED;
                                tbl_wr_idx       = r_last;
                            end
                        end
                        KIND_TICK: begin
                            if (r_run) begin
                                n_state     = ST_SCAN;
                                n_idx       = '0;
                                n_best_idx  = '0;
                                n_best_prio = PRIO_LIMIT;
                                n_found     = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                tbl_wr.mode_we  = upd_res.write_back;
                tbl_wr.count_we = upd_res.write_back;
                tbl_wr.data     = upd_entry;
                if (upd_res.cand) begin
                    n_best_idx  = r_idx;
                    n_best_prio = rd_entry.prio;
                    n_found     = 1'b1;
                end
                if (r_idx == IW'(NUM_TASKS - 1)) begin
                    n_state = ST_DISP;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_DISP: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_disp  = r_found;
                    n_out_task  = r_found ? TIDX_W'(r_best_idx) : '0;
                    if (r_found) begin
                        tbl_wr.mode_we   = 1'b1;
                        tbl_wr.data.mode = MODE_RUNNING;
                        tbl_wr_idx       = r_best_idx;
                        n_last           = r_best_idx;
                        n_disp_made      = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last      <= '0;
            r_disp_made <= 1'b0;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_disp_made <= n_disp_made;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_run <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_best_idx  <= n_best_idx;
        r_best_prio <= n_best_prio;
        r_found     <= n_found;
        r_out_disp  <= n_out_disp;
        r_out_task  <= n_out_task;
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {{(8 - TIDX_W){1'b0}}, r_out_task};
    assign m_axis_tuser[0] = r_out_disp;

    a_scan_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (32'(r_idx) < NUM_TASKS))
        else $error("scan index beyond task table");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_idx == '0) |-> $past(in_accept))
        else $error("scan started without an accepted tick");

    a_disp_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> r_disp_made)
        else $error("dispatch result without dispatch history");

    a_no_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'd0))
        else $error("task index set with no dispatch");

    a_disp_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DISP && out_free) |=> (m_axis_tvalid && r_state == ST_IDLE))
        else $error("result not loaded after dispatch step");

endmodule
`default_nettype wire

FILE: verif/priority_sleep_task_scheduler_tb.sv
// self-checking testbench for the priority sleep task scheduler
`timescale 1ns / 100ps
module priority_sleep_task_scheduler_tb;
    import pss_pkg::*;

    localparam int N_TASKS     = 8;
    localparam int SETTLE_CYC  = N_TASKS + 10;
    localparam int HOLD_CYC    = 300;
    localparam int STALL_LIMIT = 3000;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIDX_W-1:0] idx;
        logic [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  rel;
        logic [MODE_W-1:0] st;
    } t_item;

    typedef struct packed {
        logic              hit;
        logic [TIDX_W-1:0] pick;
    } t_pick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // task_index, new_priority, new_count, new_reload, new_state
    logic [1:0]  s_axis_tuser = '0;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;       // chosen_task
    logic [0:0]  m_axis_tuser;       // dispatched
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_data = '0;    // run_enable

    // scheduler model state
    logic              tbl_used   [N_TASKS];
    logic [MODE_W-1:0] tbl_mode   [N_TASKS];
    logic [CNT_W-1:0]  tbl_count  [N_TASKS];
    logic [PRIO_W-1:0] tbl_prio   [N_TASKS];
    logic [CNT_W-1:0]  tbl_reload [N_TASKS];
    logic [TIDX_W-1:0] last_pick;
    logic              pick_made;
    logic              run_en;

    t_item pending_items[$];
    t_pick dispatch_q[$];

    int  n_pushed     = 0;
    int  n_accepted   = 0;
    int  err_cnt      = 0;
    int  quiet_cycles = 0;
    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    int  hold_reqs    = 0;
    int  hold_served  = 0;
    int  hold_left    = 0;
    bit  s_took       = 1'b0;

    priority_sleep_task_scheduler #(
        .NUM_TASKS(N_TASKS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // apply one accepted item to the model, queue the dispatch decision of enabled ticks
    task automatic schedule_item(input t_item it);
        int   best_prio;
        int   best_idx;
        bit   found;
        t_pick res;
        case (it.kind)
            KIND_ASSIGN: begin
                tbl_used[it.idx]   = 1'b1;
                tbl_prio[it.idx]   = it.prio;
                tbl_count[it.idx]  = it.cnt;
                tbl_reload[it.idx] = it.rel;
                tbl_mode[it.idx]   = it.st;
            end
            KIND_FAIL: begin
                if (pick_made) tbl_mode[last_pick] = MODE_KILLED;
            end
            KIND_TICK: begin
                if (run_en) begin
                    for (int i = 0; i < N_TASKS; i++) begin
                        if (!tbl_used[i]) continue;
                        if (tbl_count[i] == '0) begin
                            tbl_mode[i]  = MODE_READY;
                            tbl_count[i] = tbl_reload[i];
                        end else if (tbl_mode[i] == MODE_RUNNING) begin
                            tbl_mode[i] = MODE_SLEEPING;
                        end else if (tbl_mode[i] == MODE_SLEEPING) begin
                            tbl_count[i] = tbl_count[i] - 1'b1;
                        end else if (tbl_mode[i] == MODE_KILLED) begin
                            tbl_mode[i] = MODE_FINISHED;
                        end
                    end
                    best_prio = int'(PRIO_LIMIT);
                    best_idx  = 0;
                    found     = 1'b0;
                    for (int i = 0; i < N_TASKS; i++) begin
                        if (tbl_used[i] && tbl_mode[i] == MODE_READY
                                && int'(tbl_prio[i]) < best_prio) begin
                            best_prio = int'(tbl_prio[i]);
                            best_idx  = i;
                            found     = 1'b1;
                        end
                    end
                    res = '0;
                    if (found) begin
                        tbl_mode[best_idx] = MODE_RUNNING;
                        last_pick = TIDX_W'(best_idx);
                        pick_made = 1'b1;
                        res.hit   = 1'b1;
                        res.pick  = TIDX_W'(best_idx);
                    end
                    dispatch_q.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    // monitor: model update, result check and watchdog
    always @(posedge i_clk) begin : monitor
        t_item it;
        t_pick exp_res;
        bit    any_fire;
        if (!i_rst_n) begin
            s_took = 1'b0;
            for (int i = 0; i < N_TASKS; i++) begin
                tbl_used[i]   = 1'b0;
                tbl_mode[i]   = MODE_READY;
                tbl_count[i]  = '0;
                tbl_prio[i]   = '0;
                tbl_reload[i] = '0;
            end
            last_pick = '0;
            pick_made = 1'b0;
            run_en    = 1'b0;
        end else begin
            any_fire = 1'b0;
            s_took = s_axis_tvalid && s_axis_tready;
            if (s_took) begin
                it.kind = s_axis_tuser;
                it.idx  = s_axis_tdata[2:0];
                it.prio = s_axis_tdata[9:3];
                it.cnt  = s_axis_tdata[25:10];
                it.rel  = s_axis_tdata[41:26];
                it.st   = s_axis_tdata[44:42];
                schedule_item(it);
                n_accepted++;
                any_fire = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                run_en   = i_cfg_data[0];
                any_fire = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                any_fire = 1'b1;
                if (dispatch_q.size() == 0) begin
                    $error("unexpected transaction: dispatched %0d, chosen_task %0d",
                           m_axis_tuser[0], m_axis_tdata[2:0]);
                    err_cnt++;
                end else begin
                    exp_res = dispatch_q.pop_front();
                    if (m_axis_tuser[0] !== exp_res.hit) begin
                        $error("dispatched: expected %0d, actual %0d",
                               exp_res.hit, m_axis_tuser[0]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[2:0] !== exp_res.pick) begin
                        $error("chosen_task: expected %0d, actual %0d",
                               exp_res.pick, m_axis_tdata[2:0]);
                        err_cnt++;
                    end
                end
            end
            quiet_cycles = any_fire ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin : driver
        t_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_took) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= it.kind;
                s_axis_tdata  <= {3'b000, it.st, it.rel, it.cnt, it.prio, it.idx};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output ready with random stalls and long hold-offs
    always @(negedge i_clk) begin : sink
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_reqs) begin
            hold_served++;
            hold_left = HOLD_CYC;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic queue_item(input logic [KIND_W-1:0] kind, input int idx, input int prio,
                              input int cnt, input int rel, input logic [MODE_W-1:0] st);
        t_item it;
        it.kind = kind;
        it.idx  = TIDX_W'(idx);
        it.prio = PRIO_W'(prio);
        it.cnt  = CNT_W'(cnt);
        it.rel  = CNT_W'(rel);
        it.st   = st;
        pending_items.push_back(it);
        n_pushed++;
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return CNT_W'($urandom_range(3));
        if (sel < 90) return CNT_W'($urandom_range(30, 4));
        return CNT_W'($urandom_range(65535));
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    sel;
        sel = $urandom_range(99);
        if (sel < 45)      it.kind = KIND_TICK;
        else if (sel < 78) it.kind = KIND_ASSIGN;
        else if (sel < 93) it.kind = KIND_FAIL;
        else               it.kind = KIND_SPARE;
        it.idx  = TIDX_W'($urandom_range(N_TASKS - 1));
        it.prio = ($urandom_range(9) < 8) ? PRIO_W'($urandom_range(15))
                                          : PRIO_W'($urandom_range(127));
        it.cnt  = pick_count();
        it.rel  = pick_count();
        it.st   = ($urandom_range(9) < 8) ? MODE_W'($urandom_range(4))
                                          : MODE_W'($urandom_range(7));
        return it;
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (n_accepted != n_pushed || dispatch_q.size() != 0);
    endtask

    task automatic set_enable(input logic v);
        wait_drained();
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic en, input int tx, input int rx, input int n,
                             input bit hold, input bit pause);
        set_enable(en);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        if (hold) hold_reqs++;
        for (int k = 0; k < n; k++) begin
            if (pause && k == n / 2) wait_drained();
            pending_items.push_back(rand_item());
            n_pushed++;
        end
    endtask

    initial begin : stimulus
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // disabled: ticks idle, fail before any dispatch
        set_enable(1'b0);
        queue_item(KIND_ASSIGN, 0, 0, 2, 0, MODE_RUNNING);
        queue_item(KIND_TICK, 0, 0, 0, 0, MODE_READY);
        queue_item(KIND_FAIL, 0, 0, 0, 0, MODE_READY);
        queue_item(KIND_SPARE, 7, 127, 65535, 65535, 3'd7);

        set_enable(1'b1);
        queue_item(KIND_TICK, 0, 0, 0, 0, MODE_READY);
        queue_item(KIND_FAIL, 0, 0, 0, 0, MODE_READY);
        queue_item(KIND_TICK, 0, 0, 0, 0, MODE_READY);
        queue_item(KIND_TICK, 0, 0, 0, 0, MODE_READY);
        queue_item(KIND_ASSIGN, 7, 127, 65535, 65535, 3'd7);
        queue_item(KIND_ASSIGN, 5, 100, 0, 3, MODE_READY);
        queue_item(KIND_ASSIGN, 3, 99, 2, 1, MODE_SLEEPING);
        queue_item(KIND_TICK, 0, 0, 0, 0, MODE_READY);
        queue_item(KIND_FAIL, 0, 0, 0, 0, MODE_READY);
        queue_item(KIND_ASSIGN, 1, 5, 3, 2, MODE_KILLED);
        queue_item(KIND_ASSIGN, 2, 5, 1, 0, MODE_RUNNING);
        queue_item(KIND_ASSIGN, 4, 5, 0, 0, MODE_FINISHED);
        queue_item(KIND_ASSIGN, 6, 5, 0, 4, MODE_READY);
        queue_item(KIND_ASSIGN, 0, 127, 9, 9, 3'd5);
        queue_item(KIND_TICK, 0, 0, 0, 0, MODE_READY);
        queue_item(KIND_TICK, 0, 0, 0, 0, MODE_READY);
        queue_item(KIND_SPARE, 0, 0, 0, 0, MODE_READY);
        queue_item(KIND_FAIL, 0, 0, 0, 0, MODE_READY);
        queue_item(KIND_TICK, 0, 0, 0, 0, MODE_READY);

        run_phase(1'b1, 0, 0, 200, 1'b0, 1'b0);
        run_phase(1'b1, 73, 0, 180, 1'b0, 1'b0);
        run_phase(1'b1, 0, 73, 180, 1'b0, 1'b0);
        run_phase(1'b1, 9, 9, 220, 1'b1, 1'b1);
        run_phase(1'b0, 9, 9, 60, 1'b0, 1'b0);
        run_phase(1'b1, 0, 0, 160, 1'b0, 1'b0);
        run_phase(1'b1, 9, 9, 120, 1'b1, 1'b0);

        wait_drained();
        repeat (SETTLE_CYC) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
